@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/bps_pkg.sv @@
// Package with types, codes and constants of the beat pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none
package bps_pkg;

	// Pattern length and step index width.
	localparam int STEPS  = 8;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	// Divider numerator width: double ticks per minute plus bpm.
	localparam int NUM_W = 25;
	localparam int DEN_W = 9;
	localparam int CNT_W = 5;

	// Item kinds.
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_BUTTON = 2'd1;
	localparam logic [1:0] MODE_TEMPO  = 2'd2;

	// Register indexes of the write port.
	localparam logic [2:0] REG_PATTERN  = 3'd0;
	localparam logic [2:0] REG_PULSE    = 3'd1;
	localparam logic [2:0] REG_DEBOUNCE = 3'd2;
	localparam logic [2:0] REG_MIN_BPM  = 3'd3;
	localparam logic [2:0] REG_MAX_BPM  = 3'd4;
	localparam logic [2:0] REG_DTPM     = 3'd5;

	// Reset values.
	localparam logic [7:0]  RST_PATTERN  = 8'd85;
	localparam logic [15:0] RST_PULSE    = 16'd4101;
	localparam logic [15:0] RST_DEBOUNCE = 16'd200;
	localparam logic [7:0]  RST_MIN_BPM  = 8'd40;
	localparam logic [7:0]  RST_MAX_BPM  = 8'd220;
	localparam logic [23:0] RST_DTPM     = 24'd4921875;
	localparam logic [15:0] RST_PERIOD   = 16'd20508;
	localparam logic [15:0] RST_HALF     = 16'd10254;
	localparam logic [7:0]  RST_TEMPO    = 8'd120;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic mul;
		logic div_load;
		logic div_step;
		logic apply;
		logic load_out;
	} bps_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tempo;
		logic bpm_ok;
		logic div_last;
	} bps_status_t;

	// One result beat.
	typedef struct packed {
		logic        led_on;
		logic        running;
		logic [2:0]  next_step;
		logic [7:0]  tempo_bpm;
		logic [15:0] period_ticks;
		logic        step_played;
	} bps_result_t;

endpackage
`default_nettype wire

@@ rtl/core/bps_item_if.sv @@
// Input channel interface: one item beat with kind, time stamp and reading.
`timescale 1ns / 1ps
`default_nettype none
interface bps_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] time_ms;
	logic [11:0] adc_value;

	modport source (output valid, output mode, output time_ms, output adc_value, input ready);
	modport sink (input valid, input mode, input time_ms, input adc_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bps_result_if.sv @@
// Output channel interface: one result beat with LED, run and tempo state.
`timescale 1ns / 1ps
`default_nettype none
interface bps_result_if;
	logic        valid;
	logic        ready;
	logic        led_on;
	logic        running;
	logic [2:0]  next_step;
	logic [7:0]  tempo_bpm;
	logic [15:0] period_ticks;
	logic        step_played;

	modport source (output valid, output led_on, output running, output next_step,
		output tempo_bpm, output period_ticks, output step_played, input ready);
	modport sink (input valid, input led_on, input running, input next_step,
		input tempo_bpm, input period_ticks, input step_played, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bps_div.sv @@
// Restoring divider, one quotient bit per cycle while step is high, for the beat period.
`timescale 1ns / 1ps
`default_nettype none
module bps_div import bps_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic             step,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [NUM_W-1:0] quot,
	output logic                  last
);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// Shift in the next numerator bit and try to subtract the divisor.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// The numerator register fills with quotient bits from the bottom.
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (step) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
		end
	end

	// Bit counter: the step taken at zero is the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CNT_W'(NUM_W - 1);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign quot = num_q;
	assign last = cnt_q == '0;

endmodule
`default_nettype wire

@@ rtl/core/bps_dp.sv @@
// Datapath: configuration, metronome state, tempo scaling and result register.
`timescale 1ns / 1ps
`default_nettype none
module bps_dp import bps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bps_cmd_t    cmd,
	output bps_status_t      status,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] time_ms,
	input  wire logic [11:0] adc_value,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [23:0] wr_data,
	output bps_result_t      result
);

	// Configuration registers.
	logic [7:0]  pattern_q;
	logic [15:0] pulse_q;
	logic [15:0] debounce_q;
	logic [7:0]  min_bpm_q;
	logic [7:0]  max_bpm_q;
	logic [23:0] dtpm_q;

	// Metronome state.
	logic [15:0]       tick_q;
	logic [15:0]       period_q;
	logic [15:0]       half_q;
	logic [7:0]        tempo_q;
	logic [STEP_W-1:0] step_q;
	logic              led_q;
	logic [15:0]       offc_q;
	logic              run_q;
	logic [31:0]       last_q;

	// Captured item and per-item working registers.
	logic [1:0]  mode_q;
	logic [31:0] time_q;
	logic [11:0] adc_q;
	logic [7:0]  bpm_q;
	logic        played_q;
	bps_result_t result_q;

	// Next-state values for a tick or button beat.
	logic [15:0]       tick_n;
	logic              led_n;
	logic [15:0]       offc_n;
	logic [STEP_W-1:0] step_n;
	logic              run_n;
	logic [31:0]       last_n;
	logic              played_n;
	logic              fire;
	logic [16:0]       inc;
	logic              wrap;
	logic [4:0]        idx;
	logic [31:0]       elapsed;

	// Tempo path signals.
	logic [7:0]       diff;
	logic [19:0]      prod;
	logic [8:0]       sum;
	logic [7:0]       bpm_sel;
	logic [NUM_W-1:0] quot;
	logic             div_last;
	logic [15:0]      cand_period;
	logic             period_ok;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= RST_PATTERN;
			pulse_q    <= RST_PULSE;
			debounce_q <= RST_DEBOUNCE;
			min_bpm_q  <= RST_MIN_BPM;
			max_bpm_q  <= RST_MAX_BPM;
			dtpm_q     <= RST_DTPM;
		end else if (wr_en) begin
			case (wr_index)
				REG_PATTERN:  pattern_q  <= wr_data[7:0];
				REG_PULSE:    pulse_q    <= wr_data[15:0];
				REG_DEBOUNCE: debounce_q <= wr_data[15:0];
				REG_MIN_BPM:  min_bpm_q  <= wr_data[7:0];
				REG_MAX_BPM:  max_bpm_q  <= wr_data[7:0];
				REG_DTPM:     dtpm_q     <= wr_data;
				default: ;
			endcase
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			time_q <= time_ms;
			adc_q  <= adc_value;
		end
	end

	assign elapsed = time_q - last_q;

	// Tick and button handling, with the step play that either may fire.
	always_comb begin
		tick_n   = tick_q;
		led_n    = led_q;
		offc_n   = offc_q;
		step_n   = step_q;
		run_n    = run_q;
		last_n   = last_q;
		played_n = 1'b0;
		fire     = 1'b0;
		inc      = {1'b0, tick_q} + 17'd1;
		wrap     = 1'b0;
		idx      = 5'(step_q);
		case (mode_q)
			MODE_TICK: begin
				if (run_q) begin
					wrap   = inc >= {1'b0, period_q};
					tick_n = wrap ? 16'd0 : inc[15:0];
					if (tick_n == offc_q) begin
						led_n = 1'b0;
					end
					fire = wrap || (tick_n == half_q);
				end
			end
			MODE_BUTTON: begin
				if (elapsed >= {16'd0, debounce_q}) begin
					last_n = time_q;
					led_n  = 1'b0;
					if (run_q) begin
						run_n = 1'b0;
					end else begin
						run_n  = 1'b1;
						tick_n = 16'd0;
						step_n = '0;
						fire   = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (fire) begin
			idx = 5'(step_n);
			if (idx < 5'd8 && pattern_q[idx[2:0]]) begin
				led_n    = 1'b1;
				offc_n   = pulse_q + (idx[0] ? half_q : 16'd0);
				played_n = 1'b1;
			end
			step_n = (step_n == STEP_W'(STEPS - 1)) ? '0 : STEP_W'(step_n + 1'b1);
		end
	end

	// Reading scaled to bpm and clamped to the upper limit.
	assign diff    = max_bpm_q - min_bpm_q;
	assign prod    = 20'(adc_q) * 20'(diff);
	assign sum     = 9'(min_bpm_q) + 9'(prod[19:12]);
	assign bpm_sel = (sum > 9'(max_bpm_q)) ? max_bpm_q : sum[7:0];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			bpm_q <= bpm_sel;
		end
	end

	// Period division: (D + bpm) / (2 * bpm).
	bps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cmd.div_load),
		.step   (cmd.div_step),
		.num    (NUM_W'(dtpm_q) + NUM_W'(bpm_q)),
		.den    ({bpm_q, 1'b0}),
		.quot   (quot),
		.last   (div_last)
	);

	assign cand_period = quot[15:0];
	assign period_ok   = (quot != '0) && (quot[NUM_W-1:16] == '0);

	// Architectural state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			period_q <= RST_PERIOD;
			half_q   <= RST_HALF;
			tempo_q  <= RST_TEMPO;
			step_q   <= '0;
			led_q    <= 1'b0;
			offc_q   <= '0;
			run_q    <= 1'b0;
			last_q   <= '0;
			played_q <= 1'b0;
		end else if (cmd.capture) begin
			played_q <= 1'b0;
		end else if (cmd.exec) begin
			tick_q   <= tick_n;
			led_q    <= led_n;
			offc_q   <= offc_n;
			step_q   <= step_n;
			run_q    <= run_n;
			last_q   <= last_n;
			played_q <= played_n;
		end else if (cmd.apply && period_ok) begin
			if (tick_q > cand_period) begin
				tick_q <= '0;
			end
			tempo_q  <= bpm_q;
			period_q <= cand_period;
			half_q   <= 16'(({1'b0, cand_period} + 17'd1) >> 1);
			step_q   <= '0;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.led_on       <= led_q;
			result_q.running      <= run_q;
			result_q.next_step    <= 3'(step_q);
			result_q.tempo_bpm    <= tempo_q;
			result_q.period_ticks <= period_q;
			result_q.step_played  <= played_q;
		end
	end

	assign result = result_q;

	// Status for the controller.
	assign status.is_tempo = mode_q == MODE_TEMPO;
	assign status.bpm_ok   = (min_bpm_q <= max_bpm_q) && (bpm_q != 8'd0) && (bpm_q != tempo_q);
	assign status.div_last = div_last;

endmodule
`default_nettype wire

@@ rtl/core/bps_ctrl.sv @@
// Controller: sequences each item through execute, divide and result load.
`timescale 1ns / 1ps
`default_nettype none
module bps_ctrl import bps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire bps_status_t status,
	output bps_cmd_t         cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EXEC   = 7'b0000010,
		ST_PREP   = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_APPLY  = 7'b0010000,
		ST_RESULT = 7'b0100000,
		ST_SPARE  = 7'b1000000
	} bps_state_t;

	bps_state_t state_q;
	bps_state_t state_n;
	logic       out_valid_q;

	// Next state and commands.
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_tempo) begin
					cmd.mul = 1'b1;
					state_n = ST_PREP;
				end else begin
					cmd.exec = 1'b1;
					state_n  = ST_RESULT;
				end
			end
			ST_PREP: begin
				if (status.bpm_ok) begin
					cmd.div_load = 1'b1;
					state_n      = ST_DIV;
				end else begin
					state_n = ST_RESULT;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_n = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_n   = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Result valid: set on load, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/core/beat_pattern_sequencer.sv @@
// Top level of the beat pattern sequencer: channels, controller and datapath.
//
// Usage: each beat on the item channel is a timer tick, a start/stop button
// edge with a millisecond stamp, or a tempo knob reading. Every item gives
// exactly one beat on the result channel with the LED level, run state, next
// step, tempo and beat period after the item.
// Sequence: a tick, button edge or unused kind is executed, then its result
// is loaded, and only then is the next item taken. A tempo reading that
// passes the limit and tempo checks runs a one-bit-per-cycle divider over
// 25 numerator bits and then an apply step, even if the period is then
// rejected; any other reading skips to the result load after the checks.
// The result sits in an output register, so the next item is accepted while
// a finished result still waits. If the receiver stalls, the following item
// waits for that register before its result loads, and the item channel
// stays blocked until then.
// Reset: arst_n clears all control and restores the register and metronome
// reset values: stopped, 120 bpm, period 20508 ticks, LED off.
// Configuration writes are taken at any edge with wr_en high and must only
// be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module beat_pattern_sequencer import bps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bps_item_if.sink         item,
	bps_result_if.source     result,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [23:0] wr_data
);

	bps_cmd_t    cmd;
	bps_status_t status;
	bps_result_t res;

	// Sequencing of each item.
	bps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// State, arithmetic and result register.
	bps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.mode      (item.mode),
		.time_ms   (item.time_ms),
		.adc_value (item.adc_value),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.result    (res)
	);

	// Result payload onto the channel.
	assign result.led_on       = res.led_on;
	assign result.running      = res.running;
	assign result.next_step    = res.next_step;
	assign result.tempo_bpm    = res.tempo_bpm;
	assign result.period_ticks = res.period_ticks;
	assign result.step_played  = res.step_played;

	// An accepted item keeps the channel closed in the following cycle.
	`BPS_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready, "item accepted while busy")
	// A step that played leaves the LED lit.
	`BPS_ASSERT_NOW(a_played_lit, result.valid && result.step_played, result.led_on, "played step with LED off")
	// A stopped metronome never drives the LED.
	`BPS_ASSERT_NOW(a_stopped_dark, result.valid && !result.running, !result.led_on, "LED on while stopped")
	// The beat period is never zero.
	`BPS_ASSERT_NOW(a_period_nonzero, result.valid, result.period_ticks != 16'd0, "zero beat period")

endmodule
`default_nettype wire

@@ tb/beat_pattern_sequencer_tb.sv @@
// Testbench of the beat pattern sequencer: a directed table, then random phases, checked by a predictor.
`timescale 1ns / 1ps
module beat_pattern_sequencer_tb;
	import bps_pkg::*;

	// Item kind with no function in the block.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 155;
	localparam int DRAIN_LIMIT = 20000;

	// Results that can be read straight off the reset state.
	localparam bps_result_t IDLE_AT_RESET = '{led_on: 1'b0, running: 1'b0, next_step: 3'd0,
		tempo_bpm: RST_TEMPO, period_ticks: RST_PERIOD, step_played: 1'b0};
	localparam bps_result_t STARTED_AT_RESET = '{led_on: 1'b1, running: 1'b1, next_step: 3'd1,
		tempo_bpm: RST_TEMPO, period_ticks: RST_PERIOD, step_played: 1'b1};
	localparam bps_result_t FIRST_TICK = '{led_on: 1'b1, running: 1'b1, next_step: 3'd1,
		tempo_bpm: RST_TEMPO, period_ticks: RST_PERIOD, step_played: 1'b0};

	// One row of the directed table: a register write or an item beat.
	typedef struct {
		logic        is_cfg;
		logic [2:0]  reg_idx;
		logic [23:0] reg_val;
		logic [1:0]  mode;
		logic [31:0] stamp;
		logic [11:0] adc;
		logic        has_exp;
		bps_result_t exp_res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [23:0] wr_data;

	bps_item_if   item_bus();
	bps_result_if result_bus();

	beat_pattern_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_bus),
		.result   (result_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #10 clk = ~clk;

	// Register copies kept by the predictor.
	logic [7:0]  cfg_pattern  = RST_PATTERN;
	logic [15:0] cfg_pulse    = RST_PULSE;
	logic [15:0] cfg_debounce = RST_DEBOUNCE;
	logic [7:0]  cfg_min_bpm  = RST_MIN_BPM;
	logic [7:0]  cfg_max_bpm  = RST_MAX_BPM;
	logic [23:0] cfg_dtpm     = RST_DTPM;

	// Metronome state kept by the predictor.
	logic [15:0] tk_count      = 16'd0;
	logic [15:0] tk_period     = RST_PERIOD;
	logic [15:0] tk_half       = RST_HALF;
	logic [7:0]  cur_bpm       = RST_TEMPO;
	logic [2:0]  step_idx      = 3'd0;
	logic        led_lvl       = 1'b0;
	logic [15:0] off_at        = 16'd0;
	logic        is_running    = 1'b0;
	logic [31:0] last_press_ms = 32'd0;

	bps_result_t pending_results[$];
	int send_idle_pct;
	int recv_idle_pct;
	int n_errors = 0;
	int n_checked = 0;
	int n_lit = 0;
	int n_items[4] = '{0, 0, 0, 0};

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		n_errors++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want) begin
			report_mismatch($sformatf("result %0d, %s: got %0d, expected %0d",
				n_checked, name, got, want));
		end
	endtask

	// Plays the current step: an enabled step lights the LED and sets its off time.
	function automatic logic play_step();
		logic lit;
		lit = 1'b0;
		if (cfg_pattern[step_idx]) begin
			led_lvl = 1'b1;
			off_at = cfg_pulse + (step_idx[0] ? tk_half : 16'd0);
			lit = 1'b1;
		end
		step_idx = step_idx + 3'd1;
		return lit;
	endfunction

	// Scales a knob reading to bpm and takes a new period if it is usable.
	function automatic void apply_reading(logic [11:0] adc);
		logic [31:0] lo, hi, raw, bpm, period, dtpm;
		lo = {24'd0, cfg_min_bpm};
		hi = {24'd0, cfg_max_bpm};
		raw = {20'd0, adc};
		dtpm = {8'd0, cfg_dtpm};
		if (lo > hi)
			return;
		bpm = lo + (raw * (hi - lo)) / 32'd4096;
		if (bpm > hi)
			bpm = hi;
		if (bpm == 32'd0 || bpm == {24'd0, cur_bpm})
			return;
		period = (dtpm + bpm) / (32'd2 * bpm);
		if (period == 32'd0 || period > 32'hFFFF)
			return;
		if ({16'd0, tk_count} > period)
			tk_count = 16'd0;
		cur_bpm = bpm[7:0];
		tk_period = period[15:0];
		tk_half = 16'((period + 32'd1) >> 1);
		step_idx = 3'd0;
	endfunction

	// Advances the predicted state by one item and returns the expected result.
	function automatic bps_result_t predict_metronome(logic [1:0] m, logic [31:0] stamp,
		logic [11:0] adc);
		logic [31:0] nxt;
		logic wrap;
		logic lit;
		bps_result_t r;
		lit = 1'b0;
		case (m)
			MODE_TICK: begin
				if (is_running) begin
					nxt = {16'd0, tk_count} + 32'd1;
					wrap = nxt >= {16'd0, tk_period};
					if (wrap)
						nxt = 32'd0;
					tk_count = nxt[15:0];
					if (tk_count == off_at)
						led_lvl = 1'b0;
					if (wrap || tk_count == tk_half)
						lit = play_step();
				end
			end
			MODE_BUTTON: begin
				if (stamp - last_press_ms >= {16'd0, cfg_debounce}) begin
					last_press_ms = stamp;
					if (is_running) begin
						is_running = 1'b0;
						led_lvl = 1'b0;
					end else begin
						is_running = 1'b1;
						tk_count = 16'd0;
						step_idx = 3'd0;
						led_lvl = 1'b0;
						lit = play_step();
					end
				end
			end
			MODE_TEMPO: begin
				apply_reading(adc);
			end
			default: begin
			end
		endcase
		r.led_on = led_lvl;
		r.running = is_running;
		r.next_step = step_idx;
		r.tempo_bpm = cur_bpm;
		r.period_ticks = tk_period;
		r.step_played = lit;
		return r;
	endfunction

	function automatic row_t item_row(logic [1:0] m, logic [31:0] stamp, logic [11:0] adc);
		row_t r;
		r.is_cfg = 1'b0;
		r.reg_idx = REG_PATTERN;
		r.reg_val = 24'd0;
		r.mode = m;
		r.stamp = stamp;
		r.adc = adc;
		r.has_exp = 1'b0;
		r.exp_res = '0;
		return r;
	endfunction

	function automatic row_t checked_row(logic [1:0] m, logic [31:0] stamp, logic [11:0] adc,
		bps_result_t e);
		row_t r;
		r = item_row(m, stamp, adc);
		r.has_exp = 1'b1;
		r.exp_res = e;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [2:0] idx, logic [23:0] val);
		row_t r;
		r = item_row(MODE_TICK, 32'd0, 12'd0);
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// Drives one item beat, waits for its acceptance and queues the expected result.
	task automatic send_item(logic [1:0] m, logic [31:0] stamp, logic [11:0] adc,
		logic typed, bps_result_t typed_res);
		bps_result_t want;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.mode <= m;
		item_bus.time_ms <= stamp;
		item_bus.adc_value <= adc;
		do @(posedge clk); while (!item_bus.ready);
		want = predict_metronome(m, stamp, adc);
		if (typed)
			want = typed_res;
		pending_results.push_back(want);
		n_items[m]++;
		if (want.step_played)
			n_lit++;
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic wait_idle();
		int waited;
		waited = 0;
		item_bus.valid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
			pending_results.delete();
		end
		repeat (4) @(negedge clk);
	endtask

	// Writes one register once the block is idle and updates the predictor's copy.
	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_PATTERN:  cfg_pattern = val[7:0];
			REG_PULSE:    cfg_pulse = val[15:0];
			REG_DEBOUNCE: cfg_debounce = val[15:0];
			REG_MIN_BPM:  cfg_min_bpm = val[7:0];
			REG_MAX_BPM:  cfg_max_bpm = val[7:0];
			REG_DTPM:     cfg_dtpm = val;
			default: begin
			end
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: ready is redrawn at every falling edge.
	always @(negedge clk) begin
		result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Checks every accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		bps_result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with no expectation waiting");
			end else begin
				want = pending_results.pop_front();
				check_field("led_on", 32'(result_bus.led_on), 32'(want.led_on));
				check_field("running", 32'(result_bus.running), 32'(want.running));
				check_field("next_step", 32'(result_bus.next_step), 32'(want.next_step));
				check_field("tempo_bpm", 32'(result_bus.tempo_bpm), 32'(want.tempo_bpm));
				check_field("period_ticks", 32'(result_bus.period_ticks),
					32'(want.period_ticks));
				check_field("step_played", 32'(result_bus.step_played),
					32'(want.step_played));
				n_checked++;
			end
		end
	end

	// Stimulus: directed table first, then random phases under three idling profiles.
	initial begin
		row_t rows[$];
		logic [31:0] ms_now;
		logic [31:0] stamp;
		logic [1:0] m;
		logic [11:0] adc;
		logic [7:0] lo, hi;
		int pick;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_PATTERN;
		wr_data = 24'd0;
		item_bus.valid = 1'b0;
		item_bus.mode = MODE_TICK;
		item_bus.time_ms = 32'd0;
		item_bus.adc_value = 12'd0;
		result_bus.ready = 1'b0;
		send_idle_pct = 17;
		recv_idle_pct = 84;
		ms_now = 32'd0;

		// At reset: ignored tick, unused kind, bounced press, start, first tick.
		rows.push_back(checked_row(MODE_TICK, 32'd0, 12'd0, IDLE_AT_RESET));
		rows.push_back(checked_row(MODE_UNUSED, 32'hFFFF_FFFF, 12'hFFF, IDLE_AT_RESET));
		rows.push_back(checked_row(MODE_BUTTON, 32'd100, 12'd0, IDLE_AT_RESET));
		rows.push_back(checked_row(MODE_BUTTON, 32'd200, 12'd0, STARTED_AT_RESET));
		rows.push_back(checked_row(MODE_TICK, 32'd0, 12'd0, FIRST_TICK));
		// Knob at both ends, then a press that bounces and one that wraps the ms stamp.
		rows.push_back(item_row(MODE_TEMPO, 32'd0, 12'd0));
		rows.push_back(item_row(MODE_TEMPO, 32'd0, 12'hFFF));
		rows.push_back(item_row(MODE_BUTTON, 32'd250, 12'd0));
		rows.push_back(item_row(MODE_BUTTON, 32'hFFFF_FFFF, 12'd0));
		rows.push_back(item_row(MODE_BUTTON, 32'h0000_0010, 12'd0));
		// Register extremes: a period too long to hold is rejected.
		rows.push_back(cfg_row(REG_PATTERN, 24'hFF));
		rows.push_back(cfg_row(REG_PULSE, 24'hFFFF));
		rows.push_back(cfg_row(REG_DEBOUNCE, 24'd0));
		rows.push_back(cfg_row(REG_MIN_BPM, 24'd1));
		rows.push_back(cfg_row(REG_MAX_BPM, 24'd255));
		rows.push_back(cfg_row(REG_DTPM, 24'hFF_FFFF));
		rows.push_back(item_row(MODE_TEMPO, 32'd0, 12'd0));
		rows.push_back(item_row(MODE_TEMPO, 32'd0, 12'hFFF));
		rows.push_back(item_row(MODE_BUTTON, 32'h0000_0010, 12'd0));
		rows.push_back(item_row(MODE_BUTTON, 32'h0000_0010, 12'd0));
		// A zero tempo and inverted limits are both ignored.
		rows.push_back(cfg_row(REG_MIN_BPM, 24'd0));
		rows.push_back(cfg_row(REG_MAX_BPM, 24'd0));
		rows.push_back(item_row(MODE_TEMPO, 32'd0, 12'hFFF));
		rows.push_back(cfg_row(REG_MIN_BPM, 24'd200));
		rows.push_back(cfg_row(REG_MAX_BPM, 24'd100));
		rows.push_back(item_row(MODE_TEMPO, 32'd0, 12'h800));
		// A period of one tick, then a reading that gives a zero period.
		rows.push_back(cfg_row(REG_DTPM, 24'd1));
		rows.push_back(cfg_row(REG_MIN_BPM, 24'd1));
		rows.push_back(cfg_row(REG_MAX_BPM, 24'd1));
		rows.push_back(item_row(MODE_TEMPO, 32'd0, 12'd0));
		rows.push_back(cfg_row(REG_MIN_BPM, 24'd2));
		rows.push_back(cfg_row(REG_MAX_BPM, 24'd2));
		rows.push_back(item_row(MODE_TEMPO, 32'd0, 12'd0));
		// Every tick wraps; the odd step's off time wraps past 65535 to zero.
		rows.push_back(item_row(MODE_BUTTON, 32'h0000_0020, 12'd0));
		rows.push_back(item_row(MODE_TICK, 32'd0, 12'd0));
		rows.push_back(item_row(MODE_TICK, 32'd0, 12'd0));
		rows.push_back(item_row(MODE_TICK, 32'd0, 12'd0));
		rows.push_back(item_row(MODE_BUTTON, 32'h0000_0030, 12'd0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				write_reg(rows[i].reg_idx, rows[i].reg_val);
			else
				send_item(rows[i].mode, rows[i].stamp, rows[i].adc, rows[i].has_exp,
					rows[i].exp_res);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// Short periods so that beats, off-beats and LED timeouts come often.
			lo = 8'($urandom_range(1, 100));
			hi = 8'($urandom_range(lo, 255));
			if (ph == 2) begin
				lo = 8'd1;
				hi = 8'd255;
			end
			write_reg(REG_PATTERN, (ph == 1 || ph == 4) ? 24'hFF :
				(ph == 3) ? 24'h00 : 24'($urandom_range(0, 255)));
			write_reg(REG_PULSE, (ph == 5) ? 24'hFFFF : 24'($urandom_range(1, 12)));
			write_reg(REG_DEBOUNCE, 24'($urandom_range(0, 30)));
			write_reg(REG_MIN_BPM, {16'd0, lo});
			write_reg(REG_MAX_BPM, {16'd0, hi});
			write_reg(REG_DTPM, 24'($urandom_range(200, 6000)));

			if (ph < 2) begin
				send_idle_pct = 17;
				recv_idle_pct = 84;
			end else if (ph < 4) begin
				send_idle_pct = 84;
				recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// Mostly ticks; a stopped metronome is restarted soon by a press.
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				stamp = $urandom();
				adc = 12'($urandom_range(0, 4095));
				if (!is_running && pick < 40)
					m = MODE_BUTTON;
				else if (pick < 73)
					m = MODE_TICK;
				else if (pick < 81)
					m = MODE_BUTTON;
				else if (pick < 96)
					m = MODE_TEMPO;
				else
					m = MODE_UNUSED;
				// Presses mostly follow a running ms clock, around the debounce window.
				if (m == MODE_BUTTON) begin
					if ($urandom_range(0, 15) != 0)
						ms_now = ms_now + $urandom_range(0, 2 * cfg_debounce + 2);
					else
						ms_now = stamp;
					stamp = ms_now;
				end
				send_item(m, stamp, adc, 1'b0, '0);
			end
		end

		wait_idle();
		$display("Run covered %0d ticks, %0d button edges, %0d tempo readings, %0d unused items",
			n_items[MODE_TICK], n_items[MODE_BUTTON], n_items[MODE_TEMPO],
			n_items[MODE_UNUSED]);
		$display("%0d result beats compared, %0d lit steps, %0d random register settings",
			n_checked, n_lit, PHASES);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: the run must be over long before this.
	initial begin
		#(16_000_000);
		$display("Timeout: stimulus or results stalled");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
